>>> sv/iatp_pkg.sv
// Shared types and constants for the text address parser.
package iatp_pkg;

    // Character store depth and derived widths
    localparam int MAX_CHARS = 64;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int ADDR_W    = $clog2(MAX_CHARS);

    // Address family codes
    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    // Characters the parser looks for
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FULL   = 2'd0,
        ST_TRAIL  = 2'd1,
        ST_NONE   = 2'd2,
        ST_FAMILY = 2'd3
    } status_t;

    // Parser sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BEGIN,
        S_PHEX,
        S_G7HEX,
        S_POSTC,
        S_POSTH,
        S_POSTX,
        S_OCT,
        S_REST,
        S_DONE
    } bstate_t;

    // Who started a dotted-quad scan
    typedef enum logic [1:0] {
        CTX_V4,
        CTX_PRE6,
        CTX_POST
    } dctx_t;

    // One finished string handed to the parser
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             ovf;
        logic [1:0]       fam;
    } job_t;

    // Front to back: queued job
    typedef struct packed {
        logic valid;
        job_t job;
    } job_ch_t;

    // Back to front: queue pop, store busy and read address
    typedef struct packed {
        logic              pop;
        logic              busy;
        logic [ADDR_W-1:0] rd_addr;
    } back_ctl_t;

endpackage

>>> sv/iatp_front.sv
// Character intake, character store and one-entry job queue.
module iatp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [7:0]              ch,
    input  logic                    last,
    input  iatp_pkg::back_ctl_t     ctl,
    output iatp_pkg::job_ch_t       job_ch,
    output logic [7:0]              rd_data
);
    import iatp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

    logic [7:0]       mem [MAX_CHARS];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       fam_reg, fam_next;
    logic             end_reg, end_next;
    job_t             job_reg, job_next;
    logic             job_valid_reg, job_valid_next;
    logic             take, nonzero, room, store;
    logic [CNT_W-1:0] cnt_upd;
    logic             ovf_upd;
    logic [1:0]       fam_upd;

    // Store is owned by the parser while a job waits or runs
    assign in_stall = job_valid_reg | ctl.busy;
    assign take     = in_valid & ~in_stall;

    // Classify the incoming character
    always_comb
    begin
        nonzero = (ch != CH_NUL);
        room    = (cnt_reg < CNT_MAX);
        store   = take & ~end_reg & nonzero & room;
        fam_upd = (cnt_reg == '0 && !end_reg) ? req_type : fam_reg;
        cnt_upd = cnt_reg + CNT_W'(store);
        ovf_upd = ovf_reg | (~end_reg & nonzero & ~room);
    end

    // Next state of the intake registers and queue
    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        fam_next       = fam_reg;
        end_next       = end_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg & ~ctl.pop;
        if (take)
        begin
            fam_next = fam_upd;
            if (last)
            begin
                job_next       = '{cnt: cnt_upd, ovf: ovf_upd, fam: fam_upd};
                job_valid_next = 1'b1;
                cnt_next       = '0;
                ovf_next       = 1'b0;
                end_next       = 1'b0;
            end
            else
            begin
                cnt_next = cnt_upd;
                ovf_next = ovf_upd;
                end_next = end_reg | ~nonzero;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            fam_reg       <= FAM_V4;
            end_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            fam_reg       <= fam_next;
            end_reg       <= end_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    // Character store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= ch;
        end
        rd_data_reg <= mem[ctl.rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign job_ch  = '{valid: job_valid_reg, job: job_reg};

endmodule

>>> sv/iatp_back.sv
// Parser sequencer walking the stored text, with the result register.
module iatp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  iatp_pkg::job_ch_t       job_ch,
    input  logic [7:0]              rd_data,
    output iatp_pkg::back_ctl_t     ctl,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic                    accepted,
    output logic [63:0]             address_high,
    output logic [63:0]             address_low
);
    import iatp_pkg::*;

    bstate_t          state_reg, state_next;
    dctx_t            ctx_reg, ctx_next;
    status_t          st_reg, st_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0] gstart_reg, gstart_next;
    logic [CNT_W-1:0] mark_reg, mark_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       fam_reg, fam_next;
    logic [15:0]      acc_reg, acc_next;
    logic [2:0]       k_reg, k_next;
    logic [2:0]       pre_reg, pre_next;
    logic [3:0]       post_reg, post_next;
    logic [1:0]       oct_reg, oct_next;
    logic [31:0]      v4_reg, v4_next;
    logic [127:0]     g_reg, g_next;
    logic [127:0]     tail_reg, tail_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic             accepted_reg, accepted_next;
    logic [127:0]     addr_reg, addr_next;

    logic [7:0]       cur;
    logic             hx, dg, dec_ok;
    logic [3:0]       hv;
    logic [15:0]      dec_mul;
    logic [6:0]       gsel;
    logic [3:0]       post_lim;
    logic [31:0]      v4_new;
    status_t          rest_st, end_st;
    logic             pop;

    // Character at the scan position; past the text it is end or overflow
    assign cur = (p_reg < cnt_reg) ? rd_data : {7'd0, ovf_reg};

    // Character classes
    always_comb
    begin
        hx = 1'b1;
        dg = 1'b0;
        hv = 4'd0;
        priority if (cur >= "0" && cur <= "9")
        begin
            dg = 1'b1;
            hv = cur[3:0];
        end
        else if ((cur >= "A" && cur <= "F") || (cur >= "a" && cur <= "f"))
        begin
            hv = cur[3:0] + 4'd9;
        end
        else
        begin
            hx = 1'b0;
        end
    end

    // Octet arithmetic and small helpers
    always_comb
    begin
        dec_mul  = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0} + {12'd0, hv};
        dec_ok   = (acc_reg < 16'd256) &&
                   ((acc_reg >= 16'd100) || (acc_reg >= 16'd10 && k_reg == 3'd2) ||
                    (k_reg == 3'd1));
        gsel     = {~pre_reg, 4'b0000};
        post_lim = 4'd7 - {1'b0, pre_reg};
        v4_new   = {v4_reg[23:0], acc_reg[7:0]};
        rest_st  = (cur != CH_NUL) ? ST_TRAIL : ST_FULL;
        end_st   = (cur != CH_NUL) ? ST_TRAIL : ST_NONE;
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        st_next        = st_reg;
        p_next         = p_reg;
        gstart_next    = gstart_reg;
        mark_next      = mark_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        fam_next       = fam_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        pre_next       = pre_reg;
        post_next      = post_reg;
        oct_next       = oct_reg;
        v4_next        = v4_reg;
        g_next         = g_reg;
        tail_next      = tail_reg;
        out_valid_next = out_valid_reg & out_stall;
        status_next    = status_reg;
        accepted_next  = accepted_reg;
        addr_next      = addr_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                p_next = '0;
                if (job_ch.valid)
                begin
                    pop        = 1'b1;
                    cnt_next   = job_ch.job.cnt;
                    ovf_next   = job_ch.job.ovf;
                    fam_next   = job_ch.job.fam;
                    g_next     = '0;
                    tail_next  = '0;
                    state_next = S_BEGIN;
                end
            end

            S_BEGIN:
            begin
                acc_next  = '0;
                k_next    = '0;
                oct_next  = '0;
                pre_next  = '0;
                post_next = '0;
                priority if (fam_reg == FAM_V4)
                begin
                    ctx_next   = CTX_V4;
                    state_next = S_OCT;
                end
                else if (fam_reg == FAM_V6)
                begin
                    gstart_next = p_reg;
                    if (cur == CH_NUL)
                    begin
                        st_next    = ST_NONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PHEX;
                    end
                end
                else
                begin
                    st_next    = ST_FAMILY;
                    state_next = S_DONE;
                end
            end

            // Leading groups, each a hex group then a colon
            S_PHEX:
            begin
                priority if (k_reg < 3'd4 && hx)
                begin
                    acc_next = {acc_reg[11:0], hv};
                    k_next   = k_reg + 3'd1;
                    p_next   = p_reg + 1'b1;
                end
                else if (k_reg == 3'd0)
                begin
                    priority if (pre_reg == 3'd7 || pre_reg == 3'd6)
                    begin
                        if (cur == CH_COLON)
                        begin
                            p_next     = p_reg + 1'b1;
                            state_next = (pre_reg == 3'd7) ? S_REST : S_G7HEX;
                        end
                        else
                        begin
                            st_next    = end_st;
                            state_next = S_DONE;
                        end
                    end
                    else if (pre_reg == 3'd0)
                    begin
                        if (cur == CH_COLON)
                        begin
                            p_next     = p_reg + 1'b1;
                            state_next = S_POSTC;
                        end
                        else
                        begin
                            st_next    = ST_NONE;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_POSTC;
                    end
                end
                else
                begin
                    g_next[gsel +: 16] = acc_reg;
                    acc_next = '0;
                    k_next   = '0;
                    priority if (pre_reg == 3'd7)
                    begin
                        st_next    = rest_st;
                        state_next = S_DONE;
                    end
                    else if (cur == CH_COLON)
                    begin
                        p_next      = p_reg + 1'b1;
                        gstart_next = p_reg + 1'b1;
                        pre_next    = pre_reg + 3'd1;
                    end
                    else if (pre_reg == 3'd6)
                    begin
                        // Group may be the first octet of a dotted quad
                        p_next     = gstart_reg;
                        ctx_next   = CTX_PRE6;
                        oct_next   = '0;
                        state_next = S_OCT;
                    end
                    else
                    begin
                        st_next    = ST_NONE;
                        state_next = S_DONE;
                    end
                end
            end

            // Final group after six leading groups and a colon
            S_G7HEX:
            begin
                if (k_reg < 3'd4 && hx)
                begin
                    acc_next = {acc_reg[11:0], hv};
                    k_next   = k_reg + 3'd1;
                    p_next   = p_reg + 1'b1;
                end
                else
                begin
                    if (k_reg != 3'd0)
                    begin
                        g_next[15:0] = acc_reg;
                    end
                    st_next    = rest_st;
                    state_next = S_DONE;
                end
            end

            // Groups after the double colon: expect a colon
            S_POSTC:
            begin
                if (post_reg < post_lim && cur == CH_COLON)
                begin
                    p_next      = p_reg + 1'b1;
                    gstart_next = p_reg + 1'b1;
                    acc_next    = '0;
                    k_next      = '0;
                    state_next  = S_POSTH;
                end
                else
                begin
                    state_next = S_POSTX;
                end
            end

            S_POSTH:
            begin
                priority if (k_reg < 3'd4 && hx)
                begin
                    acc_next = {acc_reg[11:0], hv};
                    k_next   = k_reg + 3'd1;
                    p_next   = p_reg + 1'b1;
                end
                else if (k_reg == 3'd0)
                begin
                    // No group: step back onto the colon
                    p_next     = p_reg - 1'b1;
                    state_next = S_POSTX;
                end
                else
                begin
                    tail_next  = {tail_reg[111:0], acc_reg};
                    post_next  = post_reg + 4'd1;
                    mark_next  = gstart_reg;
                    state_next = S_POSTC;
                end
            end

            // End of the group list after the double colon
            S_POSTX:
            begin
                acc_next = '0;
                k_next   = '0;
                oct_next = '0;
                priority if (post_reg == 4'd0)
                begin
                    if (cur == CH_COLON)
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_REST;
                    end
                    else
                    begin
                        st_next    = ST_NONE;
                        state_next = S_DONE;
                    end
                end
                else if (cur == CH_DOT)
                begin
                    // Last group was really the first octet of a dotted quad
                    p_next     = mark_reg;
                    post_next  = post_reg - 4'd1;
                    tail_next  = {16'd0, tail_reg[127:16]};
                    ctx_next   = CTX_POST;
                    state_next = S_OCT;
                end
                else
                begin
                    st_next    = rest_st;
                    state_next = S_DONE;
                end
            end

            // Dotted quad, one decimal digit a cycle
            S_OCT:
            begin
                priority if (k_reg < 3'd3 && dg)
                begin
                    acc_next = dec_mul;
                    k_next   = k_reg + 3'd1;
                    p_next   = p_reg + 1'b1;
                end
                else if (dec_ok && oct_reg != 2'd3 && cur == CH_DOT)
                begin
                    v4_next  = v4_new;
                    acc_next = '0;
                    k_next   = '0;
                    oct_next = oct_reg + 2'd1;
                    p_next   = p_reg + 1'b1;
                end
                else if (dec_ok && oct_reg == 2'd3)
                begin
                    v4_next = v4_new;
                    if (ctx_reg == CTX_POST)
                    begin
                        tail_next = {tail_reg[95:0], v4_new};
                        post_next = post_reg + 4'd2;
                    end
                    else
                    begin
                        g_next[31:0] = v4_new;
                    end
                    st_next    = rest_st;
                    state_next = S_DONE;
                end
                else
                begin
                    // Failed quad; after six groups the group stands, text trails
                    st_next    = (ctx_reg == CTX_PRE6) ? ST_TRAIL : ST_NONE;
                    state_next = S_DONE;
                end
            end

            S_REST:
            begin
                st_next    = rest_st;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    accepted_next  = (st_reg == ST_FULL) || (st_reg == ST_TRAIL);
                    addr_next      = ((st_reg == ST_FULL) || (st_reg == ST_TRAIL)) ?
                                     (g_reg | tail_reg) : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            p_reg         <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg      <= ctx_next;
        st_reg       <= st_next;
        gstart_reg   <= gstart_next;
        mark_reg     <= mark_next;
        cnt_reg      <= cnt_next;
        ovf_reg      <= ovf_next;
        fam_reg      <= fam_next;
        acc_reg      <= acc_next;
        k_reg        <= k_next;
        pre_reg      <= pre_next;
        post_reg     <= post_next;
        oct_reg      <= oct_next;
        v4_reg       <= v4_next;
        g_reg        <= g_next;
        tail_reg     <= tail_next;
        status_reg   <= status_next;
        accepted_reg <= accepted_next;
        addr_reg     <= addr_next;
    end

    assign ctl          = '{pop: pop,
                            busy: (state_reg != S_IDLE) && (state_reg != S_DONE),
                            rd_addr: p_next[ADDR_W-1:0]};
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign accepted     = accepted_reg;
    assign address_high = addr_reg[127:64];
    assign address_low  = addr_reg[63:0];

endmodule

>>> sv/ip_address_text_parser.sv
// Characters enter the store one per cycle while in_stall is low; after the final character
// the parser scans the stored characters, with an extra step for each group after a double
// colon and a rescan of a dotted quad where one is found.
// One string at a time; the scan of the character store, closed to intake while it runs,
// sets the rate. The result register frees the parser. Reset (rst_n, asynchronous, active
// low) empties the store count, queue and result; the character store itself is not cleared
// and needs no clearing pass.
module ip_address_text_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        accepted,
    output logic [63:0] address_high,
    output logic [63:0] address_low
);
    import iatp_pkg::*;

    back_ctl_t  ctl;
    job_ch_t    job_ch;
    logic [7:0] rd_data;

    iatp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .ch       (ch),
        .last     (last),
        .ctl      (ctl),
        .job_ch   (job_ch),
        .rd_data  (rd_data)
    );

    iatp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ch       (job_ch),
        .rd_data      (rd_data),
        .ctl          (ctl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .accepted     (accepted),
        .address_high (address_high),
        .address_low  (address_low)
    );

    // Accepted flag agrees with the status
    a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (status == ST_FULL || status == ST_TRAIL)))
        else $error("accepted flag disagrees with status");

    // Rejected results carry a zero address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (address_high == 64'd0 && address_low == 64'd0))
        else $error("address not zero on rejected result");

    // Intake held off while the parser owns the store
    a_store_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.busy || job_ch.valid) |-> in_stall)
        else $error("intake open while store in use");

    // A queued job is only popped by an idle parser
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (job_ch.valid && !ctl.busy))
        else $error("job popped while parser busy");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the IPv4/IPv6 text address parser.
`timescale 1ns / 1ps

module testbench;
    import iatp_pkg::*;

    localparam int DEPTH     = 64;
    localparam int WD_LIMIT  = 6000;
    localparam int HOLD_LEN  = 400;

    // One character transaction, or a marker that makes the sender wait for results
    typedef struct {
        logic [1:0] fam;
        logic [7:0] chr;
        logic       fin;
        bit         wait_drain;
    } char_item_t;

    typedef struct {
        status_t     status;
        logic        acc;
        logic [63:0] hi;
        logic [63:0] lo;
    } addr_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [7:0]  ch = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        accepted;
    logic [63:0] address_high;
    logic [63:0] address_low;

    char_item_t   char_queue[$];
    addr_result_t pending_addresses[$];
    int  fail_count = 0;
    int  chars_sent = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;

    // Mirror of the parser's text state
    logic [7:0]  txt_store[DEPTH];
    int          txt_len = 0;
    bit          txt_ovf = 1'b0;
    logic [1:0]  txt_fam = '0;
    bit          txt_end = 1'b0;

    ip_address_text_parser i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .ch(ch), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .accepted(accepted),
        .address_high(address_high), .address_low(address_low)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic int char_at(int p);
        if (p < txt_len && p < DEPTH)
            return txt_store[p];
        return txt_ovf ? 1 : 0;
    endfunction

    function automatic status_t tail_status(int p);
        return (char_at(p) != 0) ? ST_TRAIL : ST_FULL;
    endfunction

    function automatic bit hex_digit(int p, output int v);
        int c;
        c = char_at(p);
        v = 0;
        if (c >= "0" && c <= "9") begin v = c - "0"; return 1; end
        if (c >= "A" && c <= "F") begin v = c - "A" + 10; return 1; end
        if (c >= "a" && c <= "f") begin v = c - "a" + 10; return 1; end
        return 0;
    endfunction

    function automatic bit octet_scan(int p, output int val, output int len);
        int acc;
        int k;
        int c;
        acc = 0;
        val = 0;
        len = 0;
        for (k = 0; k < 3; k++)
        begin
            c = char_at(p + k);
            if (!(c >= "0" && c <= "9"))
                break;
            acc = acc * 10 + (c - "0");
        end
        if (acc >= 256) return 0;
        if (acc >= 100) len = 3;
        else if (acc >= 10 && k == 2) len = 2;
        else if (k == 1) len = 1;
        else return 0;
        val = acc;
        return 1;
    endfunction

    function automatic bit quad_scan(int p, output logic [31:0] addr, output int len);
        int q;
        int v;
        int n;
        logic [31:0] a;
        q = p;
        a = '0;
        addr = '0;
        len = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (!octet_scan(q, v, n))
                return 0;
            q += n;
            if (k < 3)
            begin
                if (char_at(q) != CH_DOT)
                    return 0;
                q++;
            end
            a = {a[23:0], v[7:0]};
        end
        addr = a;
        len = q - p;
        return 1;
    endfunction

    function automatic bit group_scan(int p, output logic [15:0] val, output int len);
        int k;
        int d;
        logic [15:0] acc;
        acc = '0;
        for (k = 0; k < 4; k++)
        begin
            if (!hex_digit(p + k, d))
                break;
            acc = {acc[11:0], d[3:0]};
        end
        val = acc;
        len = k;
        return k != 0;
    endfunction

    function automatic status_t v6_parse(output logic [15:0] g[8]);
        int p;
        int n;
        int pre;
        int post;
        int last_n;
        logic [15:0] v;
        logic [31:0] a;
        logic [15:0] t[8];
        p = 0;
        last_n = 0;
        for (int i = 0; i < 8; i++)
        begin
            g[i] = '0;
            t[i] = '0;
        end
        if (char_at(0) == 0)
            return ST_NONE;

        for (pre = 0; pre < 7; pre++)
        begin
            if (!group_scan(p, v, n))
                break;
            g[pre] = v;
            if (char_at(p + n) != CH_COLON)
                break;
            p += n + 1;
        end

        if (pre == 7)
        begin
            if (group_scan(p, v, n)) begin g[7] = v; return tail_status(p + n); end
            if (char_at(p) == CH_COLON) return tail_status(p + 1);
            return (char_at(p) == 0) ? ST_NONE : ST_TRAIL;
        end
        if (pre == 6)
        begin
            if (quad_scan(p, a, n))
            begin
                g[6] = a[31:16];
                g[7] = a[15:0];
                return tail_status(p + n);
            end
            if (char_at(p) == CH_COLON && group_scan(p + 1, v, n))
            begin
                g[7] = v;
                return tail_status(p + 1 + n);
            end
            if (char_at(p) == CH_COLON) return tail_status(p + 1);
            return (char_at(p) == 0) ? ST_NONE : ST_TRAIL;
        end

        if (pre == 0)
        begin
            if (char_at(p) != CH_COLON) return ST_NONE;
            p++;
        end

        for (post = 0; post < 7 - pre; post++)
        begin
            if (char_at(p) != CH_COLON || !group_scan(p + 1, v, n))
                break;
            t[post] = v;
            last_n = n + 1;
            p += n + 1;
        end

        if (post == 0)
        begin
            if (char_at(p) != CH_COLON) return ST_NONE;
            return tail_status(p + 1);
        end

        // Dot after the last group: rescan that group as a dotted quad
        if (char_at(p) == CH_DOT)
        begin
            p = p - last_n + 1;
            post--;
            if (!quad_scan(p, a, n))
                return ST_NONE;
            p += n;
            t[post & 7] = a[31:16];
            post++;
            t[post & 7] = a[15:0];
            post++;
        end

        for (int i = post - 1, j = 7; i >= 0 && j >= 0; i--, j--)
            g[j] = t[i];
        return tail_status(p);
    endfunction

    // Applies one accepted character; queues the address when the string ends
    task automatic absorb_char(logic [1:0] fam, logic [7:0] c, logic fin);
        addr_result_t r;
        logic [15:0] g[8];
        logic [31:0] a;
        int n;
        if (txt_len == 0 && !txt_end)
            txt_fam = fam;
        if (!txt_end)
        begin
            if (c == CH_NUL) txt_end = 1'b1;
            else if (txt_len < DEPTH) txt_store[txt_len++] = c;
            else txt_ovf = 1'b1;
        end
        if (!fin)
            return;
        r.hi = '0;
        r.lo = '0;
        if (txt_fam == FAM_V4)
        begin
            if (char_at(0) != 0 && quad_scan(0, a, n))
            begin
                r.status = tail_status(n);
                r.lo = {32'd0, a};
            end
            else
                r.status = ST_NONE;
        end
        else if (txt_fam == FAM_V6)
        begin
            r.status = v6_parse(g);
            if (r.status != ST_NONE)
            begin
                r.hi = {g[0], g[1], g[2], g[3]};
                r.lo = {g[4], g[5], g[6], g[7]};
            end
        end
        else
            r.status = ST_FAMILY;
        r.acc = (r.status == ST_FULL || r.status == ST_TRAIL);
        pending_addresses.push_back(r);
        txt_len = 0;
        txt_ovf = 1'b0;
        txt_end = 1'b0;
    endtask

    // ---------------------------------------------------------------- stimulus
    task automatic queue_text(logic [1:0] fam, string s);
        char_item_t it;
        it.wait_drain = 1'b0;
        for (int i = 0; i < s.len(); i++)
        begin
            it.fam = (i == 0) ? fam : 2'($urandom_range(0, 3));
            it.chr = s[i];
            it.fin = (i == s.len() - 1);
            char_queue.push_back(it);
        end
    endtask

    // Empty string or one ending in a zero byte then junk
    task automatic queue_nul_text(logic [1:0] fam, string s, int junk);
        char_item_t it;
        it.wait_drain = 1'b0;
        for (int i = 0; i < s.len(); i++)
        begin
            it.fam = (i == 0) ? fam : 2'($urandom_range(0, 3));
            it.chr = s[i];
            it.fin = 1'b0;
            char_queue.push_back(it);
        end
        it.fam = fam;
        it.chr = CH_NUL;
        it.fin = (junk == 0);
        char_queue.push_back(it);
        for (int i = 0; i < junk; i++)
        begin
            it.fam = 2'($urandom_range(0, 3));
            it.chr = 8'($urandom_range(0, 255));
            it.fin = (i == junk - 1);
            char_queue.push_back(it);
        end
    endtask

    task automatic queue_drain_wait();
        char_item_t it;
        it.fam = '0;
        it.chr = '0;
        it.fin = 1'b0;
        it.wait_drain = 1'b1;
        char_queue.push_back(it);
    endtask

    function automatic string rand_octet();
        case ($urandom_range(0, 5))
            0: return $sformatf("%0d", $urandom_range(0, 9));
            1: return $sformatf("%0d", $urandom_range(10, 99));
            2: return $sformatf("%0d", $urandom_range(250, 255));
            3: return $sformatf("%0d", $urandom_range(256, 999));
            4: return $sformatf("0%0d", $urandom_range(0, 99));
            default: return $sformatf("%0d", $urandom_range(0, 255));
        endcase
    endfunction

    function automatic string rand_quad();
        return $sformatf("%s.%s.%s.%s", rand_octet(), rand_octet(), rand_octet(),
                         rand_octet());
    endfunction

    function automatic string rand_group();
        string s;
        string hexset;
        hexset = "0123456789abcdefABCDEF";
        s = "";
        for (int i = $urandom_range(1, 5); i > 0; i--)
            s = {s, string'(hexset[$urandom_range(0, 21)])};
        return s;
    endfunction

    function automatic string rand_v6();
        string s;
        int n;
        int gap;
        n = $urandom_range(0, 8);
        gap = $urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, n);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            if (i == gap) s = {s, "::"};
            else if (i != 0) s = {s, ":"};
            s = {s, rand_group()};
        end
        if (gap == n) s = {s, "::"};
        if ($urandom_range(0, 4) == 0) s = {s, ":", rand_quad()};
        return s;
    endfunction

    // Random corruption of a well-formed text
    function automatic string mangle(string s);
        string noise;
        noise = ".:0aG ";
        if (s.len() > 0 && $urandom_range(0, 2) == 0)
            s[$urandom_range(0, s.len() - 1)] = noise[$urandom_range(0, 5)];
        if ($urandom_range(0, 2) == 0)
            s = {s, string'(8'($urandom_range(1, 255)))};
        return s;
    endfunction

    function automatic string long_text();
        string s;
        s = "";
        for (int i = $urandom_range(60, 75); i > 0; i--)
            s = {s, string'($urandom_range(0, 1) ? CH_DOT + 8'h03 : CH_COLON)};
        return s;
    endfunction

    initial
    begin
        string s;
        int total;
        // Directed strings
        queue_text(FAM_V4, "192.168.0.1");
        queue_text(FAM_V4, "255.255.255.255");
        queue_text(FAM_V4, "0.0.0.0");
        queue_text(FAM_V4, "01.2.3.4");
        queue_text(FAM_V4, "256.1.1.1");
        queue_text(FAM_V4, "1.2.3.4x");
        queue_text(FAM_V6, "::");
        queue_text(FAM_V6, "::1");
        queue_text(FAM_V6, "1:2:3:4:5:6:7:8");
        queue_text(FAM_V6, "ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff");
        queue_text(FAM_V6, "::ffff:10.0.0.1");
        queue_text(FAM_V6, "1:2:3:4:5:6:9.8.7.6");
        queue_text(FAM_V6, "1:2:3:4:5:6:zz");
        queue_text(FAM_V6, "1:2:3:4:5:6:7:");
        queue_text(FAM_V6, "1:2:3:4:5:6:7");
        queue_text(FAM_V6, "a::b.1.2.3");
        queue_text(2'd2, "1.2.3.4");
        queue_text(2'd3, "::1");
        queue_nul_text(FAM_V4, "", 0);
        queue_nul_text(FAM_V6, "::1", 3);
        queue_text(FAM_V6, long_text());
        queue_drain_wait();
        // Random strings
        total = 0;
        while (total < 1300)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: s = rand_quad();
                3, 4, 5: s = rand_v6();
                6: s = mangle(rand_quad());
                7: s = mangle(rand_v6());
                default:
                begin
                    s = "";
                    for (int i = $urandom_range(1, 8); i > 0; i--)
                        s = {s, string'(8'($urandom_range(1, 255)))};
                end
            endcase
            if ($urandom_range(0, 40) == 0) s = long_text();
            total += s.len();
            if ($urandom_range(0, 15) == 0)
                queue_nul_text(2'($urandom_range(0, 3)), s, $urandom_range(0, 3));
            else if (s.len() == 0)
                queue_nul_text(FAM_V6, s, 0);
            else
                queue_text($urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3))
                                                     : 2'($urandom_range(0, 1)), s);
            if ($urandom_range(0, 150) == 0)
                queue_drain_wait();
        end
        repeat (5) @(posedge clk);
        rst_n = 1'b1;
        wait (char_queue.size() == 0);
        @(posedge clk);
        while (in_valid || pending_addresses.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- driver
    always @(negedge clk)
    begin
        logic       nv;
        char_item_t it;
        bit         quiet;
        nv = in_valid;
        quiet = (chars_sent > 500 && chars_sent < 750);
        if (rst_n && !(in_valid && !in_taken))
        begin
            nv = 1'b0;
            if (char_queue.size() != 0 && char_queue[0].wait_drain)
            begin
                if (pending_addresses.size() == 0)
                    void'(char_queue.pop_front());
            end
            else if (char_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 12))
            begin
                it = char_queue.pop_front();
                req_type <= it.fam;
                ch <= it.chr;
                last <= it.fin;
                nv = 1'b1;
            end
        end
        in_valid <= nv;
    end

    // Receiver: one long hold-off, otherwise random stalls except in a calm window
    always @(negedge clk)
    begin
        bit calm;
        calm = (chars_sent > 500 && chars_sent < 750);
        if (!hold_done && results_seen == 30)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    // ---------------------------------------------------------------- monitor
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        addr_result_t r;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            chars_sent++;
            absorb_char(req_type, ch, last);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_addresses.size() == 0)
                report_mismatch("unexpected", {62'd0, status}, '0);
            else
            begin
                r = pending_addresses.pop_front();
                if (status !== r.status)
                    report_mismatch("status", 64'(status), 64'(r.status));
                if (accepted !== r.acc)
                    report_mismatch("accepted", 64'(accepted), 64'(r.acc));
                if (address_high !== r.hi) report_mismatch("address_high", address_high, r.hi);
                if (address_low !== r.lo) report_mismatch("address_low", address_low, r.lo);
            end
            results_seen++;
        end
        // Watchdog on cycles without any transaction
        if (in_taken || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= WD_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
